/* sv/csr_pkg.sv */
package csr_pkg;

  localparam int MAX_RECORDS = 64;
  localparam int CNT_W = $clog2(MAX_RECORDS + 1);
  localparam int ADDR_W = $clog2(MAX_RECORDS);
  localparam int KEY_W = 32;
  localparam int PAY_W = 32;
  localparam int REC_W = KEY_W + PAY_W;

  // gap shrink factor 1.247330950103979 as an exact ratio
  localparam logic [63:0] SHRINK_NUM = 64'd1000000000000000;
  localparam logic [63:0] SHRINK_DEN = 64'd1247330950103979;

  typedef logic [CNT_W-1:0] gap_table_t [0:MAX_RECORDS];

  function automatic gap_table_t gap_table_build();
    gap_table_t t;
    for (int g = 0; g <= MAX_RECORDS; g++) begin
      t[g] = CNT_W'((64'(g) * SHRINK_NUM) / SHRINK_DEN);
    end
    return t;
  endfunction

  localparam gap_table_t GAP_TABLE = gap_table_build();

  typedef struct packed {
    logic load;
    logic sort_init;
    logic pass_init;
    logic cmp_read;
    logic wr_lo;
    logic wr_hi;
    logic next_idx;
    logic out_init;
    logic out_read;
    logic out_load;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic loop_go;
    logic pair_ok;
    logic key_gt;
    logic last_out;
  } status_t;

endpackage

/* sv/csr_ram.sv */
module csr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

/* sv/csr_datapath.sv */
module csr_datapath (
  input  logic                     clk,
  input  logic                     rst,
  input  csr_pkg::cmd_t            cmd,
  output csr_pkg::status_t         status,
  input  logic [csr_pkg::REC_W-1:0] in_rec,
  output logic [csr_pkg::REC_W-1:0] out_rec,
  output logic                     out_last
);

  logic [csr_pkg::CNT_W-1:0]  count;
  logic [csr_pkg::CNT_W-1:0]  gap;
  logic                       swap_seen;
  logic [csr_pkg::CNT_W-1:0]  idx;
  logic [csr_pkg::CNT_W:0]    pair_sum;
  logic                       load_wr;
  logic                       we;
  logic                       re;
  logic [csr_pkg::ADDR_W-1:0] waddr;
  logic [csr_pkg::REC_W-1:0]  wdata;
  logic [csr_pkg::REC_W-1:0]  rdata_a;
  logic [csr_pkg::REC_W-1:0]  rdata_b;

  assign pair_sum = {1'b0, idx} + {1'b0, gap};
  assign load_wr  = cmd.load && (count < csr_pkg::CNT_W'(csr_pkg::MAX_RECORDS));
  assign we       = load_wr || cmd.wr_lo || cmd.wr_hi;
  assign re       = cmd.cmp_read || cmd.out_read;

  always_comb begin
    if (cmd.load) begin
      waddr = count[csr_pkg::ADDR_W-1:0];
      wdata = in_rec;
    end else if (cmd.wr_lo) begin
      waddr = idx[csr_pkg::ADDR_W-1:0];
      wdata = rdata_b;
    end else begin
      waddr = pair_sum[csr_pkg::ADDR_W-1:0];
      wdata = rdata_a;
    end
  end

  csr_ram #(
    .WIDTH(csr_pkg::REC_W),
    .DEPTH(csr_pkg::MAX_RECORDS)
  ) u_store (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .re     (re),
    .raddr_a(idx[csr_pkg::ADDR_W-1:0]),
    .raddr_b(pair_sum[csr_pkg::ADDR_W-1:0]),
    .rdata_a(rdata_a),
    .rdata_b(rdata_b)
  );

  assign status.loop_go  = (gap > csr_pkg::CNT_W'(1)) || swap_seen;
  assign status.pair_ok  = pair_sum < {1'b0, count};
  assign status.key_gt   = $signed(rdata_a[csr_pkg::KEY_W-1:0]) >
                           $signed(rdata_b[csr_pkg::KEY_W-1:0]);
  assign status.last_out = ({1'b0, idx} + (csr_pkg::CNT_W + 1)'(1)) == {1'b0, count};

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      gap       <= '0;
      swap_seen <= 1'b0;
      idx       <= '0;
    end else begin
      if (load_wr) begin
        count <= count + csr_pkg::CNT_W'(1);
      end else if (cmd.finish) begin
        count <= '0;
      end
      if (cmd.sort_init) begin
        gap       <= count;
        swap_seen <= 1'b0;
      end else if (cmd.pass_init) begin
        if (gap > csr_pkg::CNT_W'(1)) begin
          gap <= csr_pkg::GAP_TABLE[gap];
        end
        swap_seen <= 1'b0;
      end else if (cmd.wr_lo) begin
        swap_seen <= 1'b1;
      end
      if (cmd.pass_init || cmd.out_init) begin
        idx <= '0;
      end else if (cmd.next_idx) begin
        idx <= idx + csr_pkg::CNT_W'(1);
      end
    end
  end

  // output holding register, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_rec  <= rdata_a;
      out_last <= status.last_out;
    end
  end

endmodule

/* sv/csr_ctrl.sv */
module csr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tlast,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  csr_pkg::status_t  status,
  output csr_pkg::cmd_t     cmd
);

  localparam logic [3:0] ST_LOAD     = 4'd0;
  localparam logic [3:0] ST_SORT_INI = 4'd1;
  localparam logic [3:0] ST_PASS     = 4'd2;
  localparam logic [3:0] ST_PAIR     = 4'd3;
  localparam logic [3:0] ST_CMP      = 4'd4;
  localparam logic [3:0] ST_SWAP2    = 4'd5;
  localparam logic [3:0] ST_OUT_RD   = 4'd6;
  localparam logic [3:0] ST_OUT_LD   = 4'd7;
  localparam logic [3:0] ST_OUT_HOLD = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  assign s_tready = (state == ST_LOAD);
  assign m_tvalid = (state == ST_OUT_HOLD);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_LOAD: begin
        if (s_tvalid) begin
          cmd.load = 1'b1;
          if (s_tlast) begin
            state_next = ST_SORT_INI;
          end
        end
      end
      ST_SORT_INI: begin
        cmd.sort_init = 1'b1;
        state_next    = ST_PASS;
      end
      ST_PASS: begin
        if (status.loop_go) begin
          cmd.pass_init = 1'b1;
          state_next    = ST_PAIR;
        end else begin
          cmd.out_init = 1'b1;
          state_next   = ST_OUT_RD;
        end
      end
      ST_PAIR: begin
        if (status.pair_ok) begin
          cmd.cmp_read = 1'b1;
          state_next   = ST_CMP;
        end else begin
          state_next = ST_PASS;
        end
      end
      ST_CMP: begin
        if (status.key_gt) begin
          cmd.wr_lo  = 1'b1;
          state_next = ST_SWAP2;
        end else begin
          cmd.next_idx = 1'b1;
          state_next   = ST_PAIR;
        end
      end
      ST_SWAP2: begin
        // second half of the swap, read data is still held
        cmd.wr_hi    = 1'b1;
        cmd.next_idx = 1'b1;
        state_next   = ST_PAIR;
      end
      ST_OUT_RD: begin
        cmd.out_read = 1'b1;
        state_next   = ST_OUT_LD;
      end
      ST_OUT_LD: begin
        cmd.out_load = 1'b1;
        state_next   = ST_OUT_HOLD;
      end
      ST_OUT_HOLD: begin
        if (m_tready) begin
          if (status.last_out) begin
            cmd.finish = 1'b1;
            state_next = ST_LOAD;
          end else begin
            cmd.next_idx = 1'b1;
            state_next   = ST_OUT_RD;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* sv/comb_sort_records_unit.sv */
// comb sort of a record set
// input stream s_*: one record per transaction, the record with s_tlast set
// closes the set; at most 64 records are kept, later ones are dropped but a
// dropped record with s_tlast still closes the set
// output stream m_*: every kept record in ascending signed key order,
// m_tlast on the final one; the block takes no input while it sorts or
// emits, so the two streams never run at the same time
// loading: s_tready stays high until the set closes
// sorting: each pass compares the pairs in turn, reading both records of a
// pair and, when it swaps, writing the low and then the high record back;
// the record store (one write and two registered reads a cycle) sets these steps
// emitting: each record is read, loaded into m_tdata and held; a stalled
// receiver sees m_tdata and m_tlast held until m_tready, nothing is lost
// first result follows the sort start, the sort, and the read and load of it
// reset clears the record count and returns to loading; store contents are
// never cleared, only entries written in the current set are read
module comb_sort_records_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // sort_key [31:0], payload [63:32]
  input  logic        s_tlast,   // last_record
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // out_key [31:0], out_payload [63:32]
  output logic        m_tlast    // out_last
);

  csr_pkg::cmd_t    cmd;
  csr_pkg::status_t status;

  csr_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tlast (s_tlast),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .status  (status),
    .cmd     (cmd)
  );

  csr_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .status  (status),
    .in_rec  (s_tdata),
    .out_rec (m_tdata),
    .out_last(m_tlast)
  );

endmodule

/* sv/csr_checker.sv */
module csr_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [63:0] s_tdata,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic        m_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output changed while stalled");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("loading and emitting at once");

  a_close_stops_input: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready && !m_tvalid)
    else $error("input still taken after set closed");

  a_open_keeps_input: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tlast |=> s_tready)
    else $error("input stopped inside an open set");

  a_last_reopens: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
    else $error("no return to loading after final record");

endmodule

bind comb_sort_records_unit csr_checker u_csr_checker (.*);
